// File: hw/rtl/rgb2g_pkg.sv
// rgb2g_pkg: mode codes, field widths and the luma weight table for the
// RGB to gray converter. No dependencies.
`default_nettype none

package rgb2g_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned ModeW  = 4;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ProdW  = ChW + WeightW;
  localparam int unsigned SumW   = ChW + 2;
  localparam int unsigned PaddrW = 3;

  // floor(s/3) == (s * 683) >> 11 for every s up to 3*255
  localparam int unsigned DivThreeMul   = 683;
  localparam int unsigned DivThreeShift = 11;
  localparam int unsigned DivThreeMulW  = 10;

  localparam logic [ModeW-1:0] MODE_AVG     = 4'd0;
  localparam logic [ModeW-1:0] MODE_W_EVEN  = 4'd1;
  localparam logic [ModeW-1:0] MODE_BT709   = 4'd2;
  localparam logic [ModeW-1:0] MODE_BT601   = 4'd3;
  localparam logic [ModeW-1:0] MODE_DESAT   = 4'd4;
  localparam logic [ModeW-1:0] MODE_MAX     = 4'd5;
  localparam logic [ModeW-1:0] MODE_MIN     = 4'd6;
  localparam logic [ModeW-1:0] MODE_RED     = 4'd7;
  localparam logic [ModeW-1:0] MODE_GREEN   = 4'd8;
  localparam logic [ModeW-1:0] MODE_BLUE    = 4'd9;
  localparam logic [ModeW-1:0] MODE_POSTER  = 4'd10;
  localparam logic [ModeW-1:0] MODE_RESET   = MODE_POSTER;

  localparam logic [ChW-1:0] PosterMask = 8'hF0;
  localparam logic [ChW-1:0] PosterMid  = 8'h08;

  typedef struct packed {
    logic [WeightW-1:0] wr;
    logic [WeightW-1:0] wg;
    logic [WeightW-1:0] wb;
  } weights_t;

  // Q0.16 weights; each triple sums to 65536
  function automatic weights_t weights_for(input logic [ModeW-1:0] mode);
    weights_t w;
    w = '0;
    case (mode)
      MODE_W_EVEN: w = '{16'd19661, 16'd38666, 16'd7209};
      MODE_BT709:  w = '{16'd13933, 16'd46871, 16'd4732};
      MODE_BT601,
      MODE_POSTER: w = '{16'd19595, 16'd38470, 16'd7471};
      default:     w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rgb_to_gray_multimode.sv
// Throughput one pixel per clock while m_axis_tready is high. Three register
// stages (input, products/extremes, output) advance under a per-stage
// valid/ready chain, so a full pipeline holds three pixels.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets mode to 10.
// Each pixel carries the mode in force when it was taken.
`default_nettype none

module rgb_to_gray_multimode
  import rgb2g_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrW-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // pixel in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [3*ChW-1:0]      s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  // pixel out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [3*ChW-1:0]      m_axis_tdata   // out_red, out_green, out_blue, low up
);

  logic [ModeW-1:0] mode_q;
  logic             cfg_wr;
  logic             cfg_sel0;

  assign pready   = 1'b1;
  assign cfg_sel0 = (paddr[PaddrW-1] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && cfg_sel0;
  assign prdata   = cfg_sel0 ? {{(32-ModeW){1'b0}}, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_wr) begin
      mode_q <= pwdata[ModeW-1:0];
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || m_axis_tready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign s_axis_tready = adv1;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: capture
  logic [ChW-1:0]   r1_q, g1_q, b1_q;
  logic [ModeW-1:0] mode1_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && s_axis_tvalid) begin
      r1_q    <= s_axis_tdata[ChW-1:0];
      g1_q    <= s_axis_tdata[2*ChW-1:ChW];
      b1_q    <= s_axis_tdata[3*ChW-1:2*ChW];
      mode1_q <= mode_q;
    end
  end

  // stage 2: weighted products, average, extremes
  weights_t                w1;
  logic [SumW-1:0]         sum1;
  logic [SumW+DivThreeMulW-1:0] avg_prod;
  logic [ChW-1:0]          mn1, mx1;

  assign w1       = weights_for(mode1_q);
  assign sum1     = SumW'(r1_q) + SumW'(g1_q) + SumW'(b1_q);
  assign avg_prod = (SumW+DivThreeMulW)'(sum1) * (SumW+DivThreeMulW)'(DivThreeMul);

  always_comb begin
    mn1 = r1_q;
    if (g1_q < mn1) mn1 = g1_q;
    if (b1_q < mn1) mn1 = b1_q;
    mx1 = r1_q;
    if (g1_q > mx1) mx1 = g1_q;
    if (b1_q > mx1) mx1 = b1_q;
  end

  logic [ProdW-1:0] pr2_q, pg2_q, pb2_q;
  logic [ChW-1:0]   avg2_q, mn2_q, mx2_q, r2_q, g2_q, b2_q;
  logic [ModeW-1:0] mode2_q;

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      pr2_q   <= ProdW'(w1.wr) * ProdW'(r1_q);
      pg2_q   <= ProdW'(w1.wg) * ProdW'(g1_q);
      pb2_q   <= ProdW'(w1.wb) * ProdW'(b1_q);
      avg2_q  <= avg_prod[DivThreeShift +: ChW];
      mn2_q   <= mn1;
      mx2_q   <= mx1;
      r2_q    <= r1_q;
      g2_q    <= g1_q;
      b2_q    <= b1_q;
      mode2_q <= mode1_q;
    end
  end

  // stage 3: luma sum and output select
  logic [ProdW-1:0] luma_sum;
  logic [ChW-1:0]   luma;
  logic [ChW:0]     desat_sum;
  logic [ChW-1:0]   gray_v;
  logic             is_gray;
  logic [ChW-1:0]   or_d, og_d, ob_d;

  assign luma_sum  = pr2_q + pg2_q + pb2_q;
  assign luma      = luma_sum[ProdW-1 -: ChW];
  assign desat_sum = {1'b0, mn2_q} + {1'b0, mx2_q};

  always_comb begin
    gray_v  = '0;
    is_gray = 1'b1;
    or_d    = '0;
    og_d    = '0;
    ob_d    = '0;
    case (mode2_q)
      MODE_AVG:    gray_v = avg2_q;
      MODE_W_EVEN,
      MODE_BT709,
      MODE_BT601:  gray_v = luma;
      MODE_DESAT:  gray_v = desat_sum[ChW:1];
      MODE_MAX:    gray_v = mx2_q;
      MODE_MIN:    gray_v = mn2_q;
      MODE_RED: begin
        is_gray = 1'b0;
        or_d    = r2_q;
      end
      MODE_GREEN: begin
        is_gray = 1'b0;
        og_d    = g2_q;
      end
      MODE_BLUE: begin
        is_gray = 1'b0;
        ob_d    = b2_q;
      end
      MODE_POSTER: gray_v = (luma & PosterMask) | PosterMid;
      default:     is_gray = 1'b0;
    endcase
    if (is_gray) begin
      or_d = gray_v;
      og_d = gray_v;
      ob_d = gray_v;
    end
  end

  logic [3*ChW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      out_q <= {ob_d, og_d, or_d};
    end
  end

  assign m_axis_tdata = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/rgb2g_checker.sv
// rgb2g_checker: port-level checks for rgb_to_gray_multimode, bound to the top.
// Depends on rgb2g_pkg for widths.
`default_nettype none

module rgb2g_checker
  import rgb2g_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [3*ChW-1:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // input only backs off when the whole pipe is full and the output is stuck
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with room in the pipe");

  // a request flows through to the output when the sink keeps up
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("request not delivered in three cycles");

endmodule

bind rgb_to_gray_multimode rgb2g_checker u_rgb2g_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
